// ----- src/todcc_pkg.sv -----
// Package for the time-of-day calendar counter: request, response and time
// types, command codes, counter limits and the month-length table. No dependencies.
`default_nettype none

package todcc_pkg;

   typedef enum logic [2:0] {
      CMD_TICK         = 3'd0,
      CMD_START_EDIT   = 3'd1,
      CMD_BUMP_HOURS   = 3'd2,
      CMD_BUMP_MINUTES = 3'd3,
      CMD_ZERO_SECONDS = 3'd4,
      CMD_COMMIT       = 3'd5,
      CMD_LOAD         = 3'd6
   } cmd_type;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] load_month;
      logic [4:0] load_day;
      logic [4:0] load_hours;
      logic [5:0] load_minutes;
      logic [5:0] load_seconds;
   } req_type;

   typedef struct packed {
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
      logic [4:0] display_hours;
      logic [4:0] day;
      logic [3:0] month;
      logic       is_pm;
      logic       half_day_event;
      logic       new_day_event;
      logic [4:0] edit_hours;
      logic [5:0] edit_minutes;
      logic [5:0] edit_seconds;
   } rsp_type;

   typedef struct packed {
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
      logic [4:0] day;
      logic [3:0] month;
   } time_type;

   typedef struct packed {
      time_type cur;
      time_type ed;
   } clock_state_type;

   localparam logic [5:0] SEC_LAST      = 6'd59;
   localparam logic [5:0] MIN_LAST      = 6'd59;
   localparam logic [4:0] HOUR_LAST     = 5'd23;
   localparam logic [4:0] HOUR_NOON     = 5'd12;
   localparam logic [5:0] HOURS_PER_DAY = 6'd24;
   localparam logic [6:0] MINS_PER_HOUR = 7'd60;
   localparam logic [3:0] MONTH_LAST    = 4'd12;
   localparam logic [4:0] DAYS_DEFAULT  = 5'd31;

   localparam logic [4:0] MONTH_DAYS [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   localparam time_type RESET_TIME = '{
      seconds: 6'd30, minutes: 6'd9, hours: 5'd19, day: 5'd31, month: 4'd12
   };

   localparam clock_state_type RESET_STATE = '{cur: RESET_TIME, ed: RESET_TIME};

   // Length of a month; months outside one to twelve count as 31 days
   function automatic logic [4:0] month_days(input logic [3:0] month);
      logic [4:0] len;
      len = DAYS_DEFAULT;
      if (month >= 4'd1 && month <= MONTH_LAST) begin
         len = MONTH_DAYS[4'(month - 4'd1)];
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- src/todcc_step.sv -----
// Next-state and response logic for one request of the time-of-day calendar
// counter. Depends on todcc_pkg.
`default_nettype none

module todcc_step (
   input  todcc_pkg::clock_state_type state,
   input  todcc_pkg::req_type         req,
   input  logic                       twelve_hour_mode,
   output todcc_pkg::clock_state_type next_state,
   output todcc_pkg::rsp_type         rsp
);
   import todcc_pkg::*;

   time_type   cur;
   time_type   ed;
   logic       half;
   logic       new_day;
   logic [5:0] hour_sum;
   logic [6:0] min_sum;
   logic       pm;

   always_comb begin
      cur      = state.cur;
      ed       = state.ed;
      half     = 1'b0;
      new_day  = 1'b0;
      hour_sum = {1'b0, state.ed.hours} + 6'd1;
      min_sum  = {1'b0, state.ed.minutes} + 7'd1;
      case (cmd_type'(req.command))
         CMD_TICK: begin
            if (state.cur.seconds < SEC_LAST) begin
               cur.seconds = state.cur.seconds + 6'd1;
            end else begin
               cur.seconds = '0;
               if (state.cur.minutes < MIN_LAST) begin
                  cur.minutes = state.cur.minutes + 6'd1;
               end else begin
                  cur.minutes = '0;
                  if (state.cur.hours < HOUR_LAST) begin
                     cur.hours = state.cur.hours + 5'd1;
                     half      = (cur.hours == HOUR_NOON);
                  end else begin
                     cur.hours = '0;
                     half      = 1'b1;
                     new_day   = 1'b1;
                     // roll the date: past the month length go to the first
                     if (({1'b0, state.cur.day} + 6'd1) >
                         {1'b0, month_days(state.cur.month)}) begin
                        cur.day   = 5'd1;
                        cur.month = (state.cur.month >= MONTH_LAST) ? 4'd1 :
                                    state.cur.month + 4'd1;
                     end else begin
                        cur.day = state.cur.day + 5'd1;
                     end
                  end
               end
            end
         end
         CMD_START_EDIT: begin
            ed = state.cur;
         end
         CMD_BUMP_HOURS: begin
            ed.hours = (hour_sum >= HOURS_PER_DAY) ? 5'(hour_sum - HOURS_PER_DAY) :
                       hour_sum[4:0];
         end
         CMD_BUMP_MINUTES: begin
            ed.minutes = (min_sum >= MINS_PER_HOUR) ? 6'(min_sum - MINS_PER_HOUR) :
                         min_sum[5:0];
         end
         CMD_ZERO_SECONDS: begin
            ed.seconds = '0;
         end
         CMD_COMMIT: begin
            cur = state.ed;
         end
         CMD_LOAD: begin
            cur.month   = req.load_month;
            cur.day     = req.load_day;
            cur.hours   = req.load_hours;
            cur.minutes = req.load_minutes;
            cur.seconds = req.load_seconds;
         end
         default: begin
            // unused code: hold everything
         end
      endcase

      pm                 = (cur.hours >= HOUR_NOON);
      next_state.cur     = cur;
      next_state.ed      = ed;
      rsp.seconds        = cur.seconds;
      rsp.minutes        = cur.minutes;
      rsp.hours          = cur.hours;
      rsp.display_hours  = (twelve_hour_mode && pm) ? cur.hours - HOUR_NOON : cur.hours;
      rsp.day            = cur.day;
      rsp.month          = cur.month;
      rsp.is_pm          = pm;
      rsp.half_day_event = half;
      rsp.new_day_event  = new_day;
      rsp.edit_hours     = ed.hours;
      rsp.edit_minutes   = ed.minutes;
      rsp.edit_seconds   = ed.seconds;
   end

endmodule

`default_nettype wire

// ----- src/time_of_day_calendar_counter.sv -----
// Top level of the time-of-day calendar counter: request register, clock state,
// response register. Depends on todcc_pkg and todcc_step.
`default_nettype none

// Usage
//   Request channel (req_valid / req_stall / req_data): one command per request,
//   tick, start edit, bump hours, bump minutes, zero seconds, commit or load.
//   Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per
//   request, in order, showing the current time, date, display hour, the
//   noon/midnight and new-day events of a tick, and the edit copy.
//   A transfer happens on a rising edge with valid high and stall low.
//   Configuration: csr_write_enable with csr_write_data sets 12-hour display
//   mode; write it only while no request is in flight.
// Pipeline
//   A request is held in the request register and computed by the step logic as it
//   moves into the response register. One request per cycle is sustained while
//   rsp_stall is low; the whole update is one pass of the step logic between the
//   request register and the response register.
// Reset
//   Synchronous, active high. Time and edit copy return to 19:09:30 on
//   31 December, 12-hour mode is set, both register stages empty.
// Back-pressure
//   While rsp_stall is high the response holds. The request register still
//   takes one more request; req_stall rises only once it is full as well.
module time_of_day_calendar_counter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  todcc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output todcc_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);
   import todcc_pkg::*;

   logic            mode_ff;
   logic            req_valid_ff;
   req_type         req_data_ff;
   clock_state_type state_ff;
   clock_state_type state_in;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   rsp_type         rsp_in;
   logic            req_fire;
   logic            step_fire;
   logic            rsp_free;

   // The response register can take a new value when empty or being drained
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign step_fire = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign req_fire  = req_valid && !req_stall;

   todcc_step u_step (
      .state            (state_ff),
      .req              (req_data_ff),
      .twelve_hour_mode (mode_ff),
      .next_state       (state_in),
      .rsp              (rsp_in)
   );

   // 12-hour mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   // Request register: fill on accept, empty when the step consumes it
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_fire) begin
         req_valid_ff <= 1'b1;
      end else if (step_fire) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_data_ff <= req_data;
      end
   end

   // Clock state: advance only when a request is carried through
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RESET_STATE;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= step_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new day is always also a half-day event
   a_new_day_is_half_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.new_day_event || rsp_data.half_day_event))
      else $error("new-day event without half-day event");

   // A new day lands exactly on midnight
   a_new_day_at_midnight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.new_day_event) |->
         (rsp_data.hours == 5'd0 && rsp_data.minutes == 6'd0 &&
          rsp_data.seconds == 6'd0))
      else $error("new-day event away from midnight");

   // Half-day events only at noon or midnight
   a_half_day_hours: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.half_day_event) |->
         (rsp_data.hours == 5'd0 || rsp_data.hours == HOUR_NOON))
      else $error("half-day event at a wrong hour");

   // State holds when no request is carried through
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable(state_ff))
      else $error("clock state changed without a request");

   // Back-pressure only with a full request register
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff)
      else $error("request stalled with an empty request register");

endmodule

`default_nettype wire

// ----- tb/time_of_day_calendar_counter_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the time-of-day calendar counter: ticks, edit commands and
// loads go through both handshakes and every response is checked against a built-in
// predictor of the clock. Depends on todcc_pkg and time_of_day_calendar_counter.
module time_of_day_calendar_counter_test;
   import todcc_pkg::*;

   // The command field is three bits wide; the top code does nothing
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   localparam int LAST_SECOND     = 59;
   localparam int LAST_MINUTE     = 59;
   localparam int LAST_HOUR       = 23;
   localparam int NOON_HOUR       = 12;
   localparam int HOURS_IN_DAY    = 24;
   localparam int MINUTES_IN_HOUR = 60;
   localparam int DECEMBER        = 12;
   localparam int LONGEST_MONTH   = 31;
   localparam int MONTH_LENGTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   localparam int HOLD_OFF_CYCLES = 200;   // one long receiver stall to fill the pipe
   localparam int DRAIN_CYCLES    = 4;     // two register stages plus margin
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no request or response moving
   localparam int REPORT_LIMIT    = 10;

   // Predicts each response from accepted requests and checks the responses in order.
   class clock_scoreboard;
      time_type now;
      time_type edit_copy;
      bit       twelve_hour;
      rsp_type  awaited [$];
      int       responses;
      int       mismatches;
      int       ticks, half_days, new_days, year_wraps, loads, edits, unused;

      function new();
         now = '{seconds: 6'd30, minutes: 6'd9, hours: 5'd19, day: 5'd31, month: 4'd12};
         edit_copy   = now;
         twelve_hour = 1'b1;
      endfunction

      function void set_mode(bit mode);
         twelve_hour = mode;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(req_type rq);
         rsp_type ex;
         bit      half;
         bit      midnight;
         int      span;
         half     = 1'b0;
         midnight = 1'b0;
         case (rq.command)
            CMD_TICK: begin
               ticks++;
               // Cascade the carries: anything at or past its last value wraps to zero
               if (now.seconds < LAST_SECOND) begin
                  now.seconds = now.seconds + 6'd1;
               end else begin
                  now.seconds = 6'd0;
                  if (now.minutes < LAST_MINUTE) begin
                     now.minutes = now.minutes + 6'd1;
                  end else begin
                     now.minutes = 6'd0;
                     if (now.hours < LAST_HOUR) begin
                        now.hours = now.hours + 5'd1;
                        half      = (now.hours == NOON_HOUR);
                     end else begin
                        now.hours = 5'd0;
                        half      = 1'b1;
                        midnight  = 1'b1;
                        span = (now.month >= 1 && now.month <= DECEMBER) ?
                               MONTH_LENGTH[now.month - 1] : LONGEST_MONTH;
                        if (now.day + 1 > span) begin
                           now.day = 5'd1;
                           if (now.month >= DECEMBER) begin
                              now.month = 4'd1;
                              year_wraps++;
                           end else begin
                              now.month = now.month + 4'd1;
                           end
                        end else begin
                           now.day = now.day + 5'd1;
                        end
                     end
                  end
               end
            end
            CMD_START_EDIT: begin
               edits++;
               edit_copy = now;
            end
            CMD_BUMP_HOURS: begin
               edits++;
               edit_copy.hours = 5'((edit_copy.hours + 1) % HOURS_IN_DAY);
            end
            CMD_BUMP_MINUTES: begin
               edits++;
               edit_copy.minutes = 6'((edit_copy.minutes + 1) % MINUTES_IN_HOUR);
            end
            CMD_ZERO_SECONDS: begin
               edits++;
               edit_copy.seconds = 6'd0;
            end
            CMD_COMMIT: begin
               edits++;
               now = edit_copy;
            end
            CMD_LOAD: begin
               loads++;
               now.month   = rq.load_month;
               now.day     = rq.load_day;
               now.hours   = rq.load_hours;
               now.minutes = rq.load_minutes;
               now.seconds = rq.load_seconds;
            end
            default: begin
               unused++;
            end
         endcase

         half_days += half;
         new_days  += midnight;
         ex.seconds        = now.seconds;
         ex.minutes        = now.minutes;
         ex.hours          = now.hours;
         ex.is_pm          = (now.hours >= NOON_HOUR);
         ex.display_hours  = (twelve_hour && ex.is_pm) ? 5'(now.hours - NOON_HOUR) : now.hours;
         ex.day            = now.day;
         ex.month          = now.month;
         ex.half_day_event = half;
         ex.new_day_event  = midnight;
         ex.edit_hours     = edit_copy.hours;
         ex.edit_minutes   = edit_copy.minutes;
         ex.edit_seconds   = edit_copy.seconds;
         awaited.push_back(ex);
      endfunction

      function void compare_field(string name, logic [5:0] want, logic [5:0] seen);
         if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("response %0d: %s expected %0d, got %0d", responses, name, want, seen);
            end
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type ex;
         responses++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("response %0d arrived with no request outstanding", responses);
            end
            return;
         end
         ex = awaited.pop_front();
         compare_field("seconds",        ex.seconds,        got.seconds);
         compare_field("minutes",        ex.minutes,        got.minutes);
         compare_field("hours",          ex.hours,          got.hours);
         compare_field("display_hours",  ex.display_hours,  got.display_hours);
         compare_field("day",            ex.day,            got.day);
         compare_field("month",          ex.month,          got.month);
         compare_field("is_pm",          ex.is_pm,          got.is_pm);
         compare_field("half_day_event", ex.half_day_event, got.half_day_event);
         compare_field("new_day_event",  ex.new_day_event,  got.new_day_event);
         compare_field("edit_hours",     ex.edit_hours,     got.edit_hours);
         compare_field("edit_minutes",   ex.edit_minutes,   got.edit_minutes);
         compare_field("edit_seconds",   ex.edit_seconds,   got.edit_seconds);
      endfunction
   endclass

   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    req_valid        = 1'b0;
   logic    req_stall;
   req_type req_data         = '0;
   logic    rsp_valid;
   logic    rsp_stall        = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data   = 1'b0;

   clock_scoreboard board;
   int  issued          = 0;
   int  quiet_cycles    = 0;
   bit  steady          = 1'b0;   // suppress idling on both sides
   bit  hold_off_wanted = 1'b0;   // ask the receiver for one long stall

   time_of_day_calendar_counter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // Any command with a random payload, so that every load bit toggles on ignored fields too
   function automatic req_type command_request(logic [2:0] cmd);
      req_type r;
      r.command      = cmd;
      r.load_month   = 4'($urandom_range(0, 15));
      r.load_day     = 5'($urandom_range(0, 31));
      r.load_hours   = 5'($urandom_range(0, 31));
      r.load_minutes = 6'($urandom_range(0, 63));
      r.load_seconds = 6'($urandom_range(0, 63));
      return r;
   endfunction

   function automatic req_type load_request(int month, int day, int hours, int minutes,
                                            int seconds);
      req_type r;
      r.command      = CMD_LOAD;
      r.load_month   = 4'(month);
      r.load_day     = 5'(day);
      r.load_hours   = 5'(hours);
      r.load_minutes = 6'(minutes);
      r.load_seconds = 6'(seconds);
      return r;
   endfunction

   // Offer one request, maybe after a gap, and hold it until the block takes it.
   // Returns in the time step of the accepting edge with valid still high.
   task automatic send_request(input req_type item);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      issued++;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait for every outstanding response, then let the pipe settle.
   // Step past the accepting edge first so the monitor has noted the last request.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      csr_write_data   <= mode;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic shaped around the interesting boundaries: loads just short of a
   // minute, hour, noon, midnight or month end followed by ticks, full edit sessions,
   // plain tick runs, and some noise with out-of-range loads and odd commands.
   task automatic run_random(input int target);
      int first;
      int pick;
      int month;
      int day;
      int hours;
      int minutes;
      int hour_pick;
      first = issued;
      while (issued - first < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            month     = $urandom_range(1, DECEMBER);
            day       = ($urandom_range(0, 1) == 0) ? MONTH_LENGTH[month - 1] :
                        $urandom_range(1, LONGEST_MONTH);
            hour_pick = $urandom_range(0, 2);
            hours     = (hour_pick == 0) ? LAST_HOUR :
                        (hour_pick == 1) ? NOON_HOUR - 1 : $urandom_range(0, LAST_HOUR);
            minutes   = ($urandom_range(0, 3) != 0) ? LAST_MINUTE :
                        $urandom_range(0, LAST_MINUTE);
            send_request(load_request(month, day, hours, minutes,
                                      $urandom_range(50, LAST_SECOND)));
            repeat ($urandom_range(1, 12)) send_request(command_request(CMD_TICK));
         end else if (pick < 70) begin
            send_request(command_request(CMD_START_EDIT));
            repeat ($urandom_range(1, 6)) begin
               send_request(command_request(3'($urandom_range(CMD_BUMP_HOURS,
                                                              CMD_ZERO_SECONDS))));
            end
            // Now and then push the hours at least half way round the day
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(12, 26)) send_request(command_request(CMD_BUMP_HOURS));
            end
            send_request(command_request(CMD_COMMIT));
            repeat ($urandom_range(1, 4)) send_request(command_request(CMD_TICK));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 10)) send_request(command_request(CMD_TICK));
         end else if (pick < 95) begin
            send_request(load_request($urandom_range(0, 15), $urandom_range(0, 31),
                                      $urandom_range(0, 31), $urandom_range(0, 63),
                                      $urandom_range(0, 63)));
            repeat ($urandom_range(1, 4)) begin
               send_request(command_request(3'($urandom_range(CMD_TICK, CMD_COMMIT))));
            end
         end else begin
            send_request(command_request(3'($urandom_range(CMD_TICK, CMD_UNUSED))));
         end
      end
   endtask

   // Receiver: random stalls of mixed length, plus the one long hold-off on request.
   // Count the hold-off here so the sender keeps offering requests meanwhile.
   initial begin : response_side
      forever begin
         @(posedge clock);
         if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (idle_length()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: sample both channels and the register port at each rising edge, before
   // any of this edge's updates land, and feed the scoreboard. Also run the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            board.set_mode(csr_write_data);
         end
         if (req_valid && !req_stall) begin
            board.note_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_response(rsp_data);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, board.pending());
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, in 12-hour mode as left by reset.
      // Advance one second from the reset time, then cross the year end at midnight.
      send_request(command_request(CMD_TICK));
      send_request(load_request(12, 31, 23, 59, 59));
      send_request(command_request(CMD_TICK));
      // End of February in a year without leap days
      send_request(load_request(2, 28, 23, 59, 58));
      send_request(command_request(CMD_TICK));
      send_request(command_request(CMD_TICK));
      // Reach noon
      send_request(load_request(4, 30, 11, 59, 59));
      send_request(command_request(CMD_TICK));
      // All-ones load: every field but the day out of range, month past December
      send_request(load_request(15, 31, 31, 63, 63));
      send_request(command_request(CMD_TICK));
      // Month zero, day zero and just-too-large time fields
      send_request(load_request(0, 0, HOURS_IN_DAY, MINUTES_IN_HOUR, 60));
      send_request(command_request(CMD_TICK));
      // Edit session on out-of-range values: bumps wrap modulo the day and the hour
      send_request(load_request(1, 0, 31, 63, 45));
      send_request(command_request(CMD_START_EDIT));
      send_request(command_request(CMD_BUMP_HOURS));
      send_request(command_request(CMD_BUMP_MINUTES));
      send_request(command_request(CMD_ZERO_SECONDS));
      send_request(command_request(CMD_COMMIT));
      send_request(command_request(CMD_TICK));
      // Edit bumps from the last legal hour and minute
      send_request(load_request(6, 15, LAST_HOUR, LAST_MINUTE, LAST_SECOND));
      send_request(command_request(CMD_START_EDIT));
      send_request(command_request(CMD_BUMP_HOURS));
      send_request(command_request(CMD_BUMP_MINUTES));
      send_request(command_request(CMD_COMMIT));
      // Unused code leaves the state alone; then an all-zero load
      send_request(command_request(CMD_UNUSED));
      send_request(load_request(0, 0, 0, 0, 0));
      drain();

      // 24-hour display, with the long receiver hold-off at the start
      write_mode(1'b0);
      hold_off_wanted = 1'b1;
      run_random(400);
      drain();

      // 12-hour display, first a stretch at full rate with no idling at all
      write_mode(1'b1);
      steady = 1'b1;
      run_random(150);
      steady = 1'b0;
      run_random(250);
      drain();

      write_mode(1'b0);
      run_random(400);
      drain();

      write_mode(1'b1);
      run_random(400);
      drain();

      $display("Sent %0d requests in both display modes: %0d ticks, %0d noon or midnight",
               issued, board.ticks, board.half_days);
      $display("events, %0d new days, %0d year wraps, %0d loads, %0d edit and %0d unused codes",
               board.new_days, board.year_wraps, board.loads, board.edits, board.unused);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
